// ----- rtl/core/mbm_pkg.sv -----
package mbm_pkg;

   // Field widths fixed by the item formats.
   localparam int COORD_BITS = 12;
   localparam int AREA_W = 2 * COORD_BITS;
   localparam int Q16_W = 17;
   localparam int IDX_W = 7;

   // Defaults for the top-level parameters.
   localparam int MAX_CANDIDATES_DEF = 128;
   localparam int QUEUE_DEPTH_DEF = 2;

   // One quotient bit per divider step: bit 16 down to bit 0.
   localparam int DIV_STEPS = Q16_W;

   // Command codes.
   localparam logic CMD_SET_REF = 1'b0;
   localparam logic CMD_CANDIDATE = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [AREA_W-1:0] area_type;

   typedef struct packed {
      logic command;
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
      logic skip;
      logic last;
   } req_item_type;

   typedef struct packed {
      logic found;
      logic [IDX_W-1:0] best_index;
      logic [Q16_W-1:0] best_overlap;
   } rsp_item_type;

   // A classified item as it travels from the front end to the back end.
   typedef struct packed {
      logic is_ref;
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
      area_type area;
      logic skip;
      logic last;
   } work_item_type;

   // Status of the queue as the back end sees it.
   typedef struct packed {
      logic empty;
      work_item_type head;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIVIDE,
      BK_COMMIT
   } back_state_type;

   // Length of the span from lo to hi, zero when the span is inverted.
   function automatic coord_type extent(coord_type lo, coord_type hi);
      extent = (hi > lo) ? coord_type'(hi - lo) : '0;
   endfunction

endpackage

// ----- rtl/core/max_overlap_box_matcher.sv -----
// Channel   Direction  Handshake          Payload
// req_      in         req_push/req_full  req_item (command, corners, skip, last)
// rsp_      out        rsp_empty/rsp_pop  rsp_item (found, best_index, best_overlap)
// csr_      in         csr_valid/csr_ready csr_data (overlap threshold, Q1.16)
//
// A candidate box goes through the back-end states in turn: IDLE picks it up, MUL
// forms the intersection product, DIVIDE runs the serial restoring divider (one
// quotient bit a cycle) and COMMIT updates the search. Skipped candidates,
// candidates past MAX_CANDIDATES and candidates with both areas zero bypass the
// divider. Reset is synchronous and clears the search, the reference box and the
// threshold. The front end and a short queue keep taking items while the divider
// runs; a waiting result stalls the back end only when the next set also ends.
module max_overlap_box_matcher #(
   parameter int MAX_CANDIDATES = mbm_pkg::MAX_CANDIDATES_DEF,
   parameter int QUEUE_DEPTH = mbm_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   // Input items.
   input logic req_push,
   output logic req_full,
   input mbm_pkg::req_item_type req_item,
   // Result items.
   output logic rsp_empty,
   input logic rsp_pop,
   output mbm_pkg::rsp_item_type rsp_item,
   // Threshold register write.
   input logic csr_valid,
   output logic csr_ready,
   input logic [mbm_pkg::Q16_W-1:0] csr_data
);

   // The front end decodes the command and works out the box's own area, so
   // the back end only needs the intersection against the reference box.
   logic q_push;
   logic q_full;
   logic q_pop;
   mbm_pkg::work_item_type q_item;
   mbm_pkg::queue_status_type q_status;

   mbm_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_item(req_item),
      .q_push(q_push),
      .q_item(q_item),
      .q_full(q_full)
   );

   // Items wait here in order until the back end is free.
   mbm_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_item(q_item),
      .full(q_full),
      .pop(q_pop),
      .status(q_status)
   );

   // The back end holds the reference box, the threshold and the running
   // best match, runs the divider, and keeps the result in an output register
   // until it is taken.
   mbm_back #(
      .MAX_CANDIDATES(MAX_CANDIDATES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_status(q_status),
      .q_pop(q_pop),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item)
   );

endmodule

// ----- rtl/core/mbm_front.sv -----
module mbm_front (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input mbm_pkg::req_item_type req_item,
   output logic q_push,
   output mbm_pkg::work_item_type q_item,
   input logic q_full
);

   logic st_valid_ff, st_valid_in;
   mbm_pkg::work_item_type st_item_ff;
   mbm_pkg::work_item_type st_item_in;
   logic accept;

   // The stage may take a new item whenever its current one moves on.
   assign req_full = st_valid_ff && q_full;
   assign accept = req_push && !req_full;
   assign q_push = st_valid_ff && !q_full;
   assign q_item = st_item_ff;

   always_comb begin
      st_valid_in = accept || (st_valid_ff && q_full);
      st_item_in.is_ref = (req_item.command == mbm_pkg::CMD_SET_REF);
      st_item_in.left = req_item.left;
      st_item_in.top = req_item.top;
      st_item_in.right = req_item.right;
      st_item_in.bottom = req_item.bottom;
      st_item_in.area =
         mbm_pkg::area_type'(mbm_pkg::extent(req_item.left, req_item.right)) *
         mbm_pkg::area_type'(mbm_pkg::extent(req_item.top, req_item.bottom));
      st_item_in.skip = req_item.skip;
      st_item_in.last = req_item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_item_ff <= st_item_in;
      end
   end

endmodule

// ----- rtl/core/mbm_queue.sv -----
module mbm_queue #(
   parameter int DEPTH = mbm_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic push,
   input mbm_pkg::work_item_type push_item,
   output logic full,
   input logic pop,
   output mbm_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mbm_pkg::work_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.head = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/mbm_back.sv -----
module mbm_back #(
   parameter int MAX_CANDIDATES = mbm_pkg::MAX_CANDIDATES_DEF
) (
   input logic clock,
   input logic reset,
   input mbm_pkg::queue_status_type q_status,
   output logic q_pop,
   input logic csr_valid,
   output logic csr_ready,
   input logic [mbm_pkg::Q16_W-1:0] csr_data,
   output logic rsp_empty,
   input logic rsp_pop,
   output mbm_pkg::rsp_item_type rsp_item
);

   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
   localparam int REM_W = mbm_pkg::AREA_W + 1;
   localparam int STEP_W = $clog2(mbm_pkg::DIV_STEPS);
   localparam int Q16_W = mbm_pkg::Q16_W;
   localparam int IDX_W = mbm_pkg::IDX_W;

   mbm_pkg::back_state_type state_ff, state_in;

   logic [Q16_W-1:0] threshold_ff;

   mbm_pkg::work_item_type work_ff;
   mbm_pkg::coord_type ref_left_ff, ref_top_ff, ref_right_ff, ref_bottom_ff;
   mbm_pkg::area_type ref_area_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] best_index_ff, best_index_in;
   logic [Q16_W-1:0] best_overlap_ff, best_overlap_in;
   logic found_ff, found_in;

   logic eval_ff;
   mbm_pkg::area_type divisor_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [Q16_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff;

   logic out_valid_ff;
   mbm_pkg::rsp_item_type out_item_ff;

   mbm_pkg::coord_type ix, iy, lo_x, hi_x, lo_y, hi_y;
   mbm_pkg::area_type larger;
   logic active;
   logic [REM_W-1:0] shifted;
   logic ge;
   logic better;
   logic last_step;
   logic commit_go;

   // FSM outputs.
   logic take_item;
   logic do_commit;

   assign csr_ready = 1'b1;
   assign rsp_empty = !out_valid_ff;
   assign rsp_item = out_item_ff;
   assign q_pop = take_item;

   // Intersection with the stored reference box.
   always_comb begin
      lo_x = (work_ff.left > ref_left_ff) ? work_ff.left : ref_left_ff;
      hi_x = (work_ff.right < ref_right_ff) ? work_ff.right : ref_right_ff;
      lo_y = (work_ff.top > ref_top_ff) ? work_ff.top : ref_top_ff;
      hi_y = (work_ff.bottom < ref_bottom_ff) ? work_ff.bottom : ref_bottom_ff;
      ix = mbm_pkg::extent(lo_x, hi_x);
      iy = mbm_pkg::extent(lo_y, hi_y);
      larger = (work_ff.area > ref_area_ff) ? work_ff.area : ref_area_ff;
      active = (count_ff < CNT_W'(MAX_CANDIDATES)) && !work_ff.skip;
   end

   // One restoring step per cycle; the first step takes the integer bit.
   always_comb begin
      shifted = (step_ff == '0) ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
      ge = (shifted >= {1'b0, divisor_ff});
      rem_in = ge ? REM_W'(shifted - {1'b0, divisor_ff}) : shifted;
      quo_in = {quo_ff[Q16_W-2:0], ge};
      last_step = (step_ff == STEP_W'(mbm_pkg::DIV_STEPS - 1));
   end

   // Search update for the candidate in hand.
   always_comb begin
      better = eval_ff && (quo_ff > threshold_ff) && (quo_ff > best_overlap_ff);
      found_in = found_ff || better;
      best_overlap_in = better ? quo_ff : best_overlap_ff;
      best_index_in = better ? IDX_W'(count_ff) : best_index_ff;
      count_in = (count_ff < CNT_W'(MAX_CANDIDATES)) ? CNT_W'(count_ff + 1'b1) : count_ff;
      commit_go = !work_ff.last || !out_valid_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbm_pkg::BK_IDLE: begin
            if (!q_status.empty) state_in = mbm_pkg::BK_MUL;
         end
         mbm_pkg::BK_MUL: begin
            if (work_ff.is_ref) begin
               state_in = mbm_pkg::BK_IDLE;
            end else if (active && (larger != '0)) begin
               state_in = mbm_pkg::BK_DIVIDE;
            end else begin
               state_in = mbm_pkg::BK_COMMIT;
            end
         end
         mbm_pkg::BK_DIVIDE: begin
            if (last_step) state_in = mbm_pkg::BK_COMMIT;
         end
         mbm_pkg::BK_COMMIT: begin
            if (commit_go) state_in = mbm_pkg::BK_IDLE;
         end
         default: state_in = mbm_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      take_item = 1'b0;
      do_commit = 1'b0;
      unique case (state_ff)
         mbm_pkg::BK_IDLE: take_item = !q_status.empty;
         mbm_pkg::BK_COMMIT: do_commit = commit_go;
         default: begin
            take_item = 1'b0;
            do_commit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbm_pkg::BK_IDLE;
         threshold_ff <= '0;
         ref_left_ff <= '0;
         ref_top_ff <= '0;
         ref_right_ff <= '0;
         ref_bottom_ff <= '0;
         ref_area_ff <= '0;
         count_ff <= '0;
         best_index_ff <= '0;
         best_overlap_ff <= '0;
         found_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            threshold_ff <= csr_data;
         end
         if (state_ff == mbm_pkg::BK_MUL && work_ff.is_ref) begin
            ref_left_ff <= work_ff.left;
            ref_top_ff <= work_ff.top;
            ref_right_ff <= work_ff.right;
            ref_bottom_ff <= work_ff.bottom;
            ref_area_ff <= work_ff.area;
            count_ff <= '0;
            best_index_ff <= '0;
            best_overlap_ff <= '0;
            found_ff <= 1'b0;
         end
         if (do_commit) begin
            if (work_ff.last) begin
               count_ff <= '0;
               best_index_ff <= '0;
               best_overlap_ff <= '0;
               found_ff <= 1'b0;
            end else begin
               count_ff <= count_in;
               best_index_ff <= best_index_in;
               best_overlap_ff <= best_overlap_in;
               found_ff <= found_in;
            end
         end
         if (do_commit && work_ff.last) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_item) begin
         work_ff <= q_status.head;
      end
      if (state_ff == mbm_pkg::BK_MUL) begin
         eval_ff <= active;
         divisor_ff <= larger;
         rem_ff <= REM_W'(mbm_pkg::area_type'(ix) * mbm_pkg::area_type'(iy));
         quo_ff <= '0;
         step_ff <= '0;
      end else if (state_ff == mbm_pkg::BK_DIVIDE) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         step_ff <= STEP_W'(step_ff + 1'b1);
      end
      if (do_commit && work_ff.last) begin
         out_item_ff.found <= found_in;
         out_item_ff.best_index <= best_index_in;
         out_item_ff.best_overlap <= best_overlap_in;
      end
   end

endmodule

// ----- test/max_overlap_box_matcher_tb.sv -----
`timescale 1ns / 100ps

module max_overlap_box_matcher_tb;
   import mbm_pkg::*;

   localparam int CLK_PERIOD = 12;
   localparam int RESET_CYCLES = 10;
   localparam int MAX_SET = MAX_CANDIDATES_DEF;
   // The front end, the work queue and the back end can each hold a candidate,
   // so this covers anything still in flight when the last result of a phase
   // has arrived.
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES = 600;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_ITEMS = 78;

   typedef enum logic [1:0] {
      ENT_BOX,
      ENT_THRESHOLD,
      ENT_DRAIN
   } entry_kind_type;

   // One step of the stimulus stream: a box item with its lead-in gap, a
   // threshold write, or a pause until every awaited result has come.
   typedef struct packed {
      entry_kind_type kind;
      req_item_type item;
      logic [4:0] gap;
      logic [Q16_W-1:0] threshold;
      logic hold_rx;
   } stream_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_item_type req_item = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_item_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [Q16_W-1:0] csr_data = '0;

   max_overlap_box_matcher u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_item(req_item),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Handshakes seen at the last rising edge, for the falling-edge processes.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic csr_taken = 1'b0;

   stream_entry_type box_stream_q[$];
   rsp_item_type predicted_match_q[$];

   // Predictor state: the reference box, the running search and the threshold.
   coord_type anchor_l = '0, anchor_t = '0, anchor_r = '0, anchor_b = '0;
   area_type anchor_area = '0;
   int set_pos = 0;
   logic [IDX_W-1:0] best_pos = '0;
   logic [Q16_W-1:0] best_ovl = '0;
   logic have_match = 1'b0;
   logic [Q16_W-1:0] thresh_q16 = '0;

   int n_items = 0, n_refs = 0, n_skipped = 0, n_csr = 0;
   int n_results = 0, n_found = 0, n_mismatch = 0;
   int quiet_cycles = 0;

   // Generator state, used only while the stream is being built.
   req_item_type gen_ref = '0;
   bit sender_burst = 1'b0;
   int gen_counted = 0;

   // ---------------------------------------------------------------- predictor

   function automatic coord_type span_len(input coord_type lo, input coord_type hi);
      return (hi > lo) ? coord_type'(hi - lo) : '0;
   endfunction

   function automatic void clear_set();
      set_pos = 0;
      best_pos = '0;
      best_ovl = '0;
      have_match = 1'b0;
   endfunction

   // Applies one accepted item to the search; returns 1 when it ends a set.
   function automatic bit score_item(input req_item_type it, output rsp_item_type res);
      area_type cand_area, big_area;
      coord_type w, h;
      logic [47:0] ovl;
      res = '0;
      if (it.command == CMD_SET_REF) begin
         anchor_l = it.left;
         anchor_t = it.top;
         anchor_r = it.right;
         anchor_b = it.bottom;
         anchor_area = area_type'(span_len(it.left, it.right))
                       * area_type'(span_len(it.top, it.bottom));
         clear_set();
         return 1'b0;
      end
      // Positions past the end of the set table are ignored but still end sets.
      if (set_pos < MAX_SET) begin
         if (!it.skip) begin
            cand_area = area_type'(span_len(it.left, it.right))
                        * area_type'(span_len(it.top, it.bottom));
            big_area = (cand_area > anchor_area) ? cand_area : anchor_area;
            w = span_len((it.left > anchor_l) ? it.left : anchor_l,
                         (it.right < anchor_r) ? it.right : anchor_r);
            h = span_len((it.top > anchor_t) ? it.top : anchor_t,
                         (it.bottom < anchor_b) ? it.bottom : anchor_b);
            ovl = '0;
            if (big_area != '0)
               ovl = ((48'(w) * 48'(h)) << 16) / 48'(big_area);
            if (ovl > 48'(thresh_q16) && ovl > 48'(best_ovl)) begin
               best_ovl = ovl[Q16_W-1:0];
               best_pos = set_pos[IDX_W-1:0];
               have_match = 1'b1;
            end
         end
         set_pos++;
      end
      if (it.last) begin
         res.found = have_match;
         res.best_index = have_match ? best_pos : '0;
         res.best_overlap = have_match ? best_ovl : '0;
         clear_set();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic req_item_type box_item(input logic cmd, input int l, input int t,
                                             input int r, input int b,
                                             input logic skp, input logic lst);
      req_item_type it;
      it.command = cmd;
      it.left = coord_type'(l);
      it.top = coord_type'(t);
      it.right = coord_type'(r);
      it.bottom = coord_type'(b);
      it.skip = skp;
      it.last = lst;
      return it;
   endfunction

   function automatic int jitter(input int c, input int d);
      int v;
      v = c + int'($urandom_range(0, 2 * d)) - d;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   task automatic push_box(input req_item_type it, input bit hold);
      stream_entry_type e;
      e = '0;
      e.kind = ENT_BOX;
      e.item = it;
      e.gap = sender_burst ? 5'd0 : 5'($urandom_range(0, 19));
      e.hold_rx = hold;
      box_stream_q = {box_stream_q, e};
      if (it.command == CMD_SET_REF || !it.skip) gen_counted++;
   endtask

   task automatic push_control(input entry_kind_type kind, input int unsigned value);
      stream_entry_type e;
      e = '0;
      e.kind = kind;
      e.threshold = value[Q16_W-1:0];
      box_stream_q = {box_stream_q, e};
   endtask

   function automatic req_item_type pick_reference();
      int l, t, r, b, pick;
      pick = $urandom_range(0, 19);
      l = $urandom_range(0, 4095);
      t = $urandom_range(0, 4095);
      r = $urandom_range(l, 4095);
      b = $urandom_range(t, 4095);
      if (pick == 0) begin
         r = l;
      end else if (pick == 1) begin
         r = $urandom_range(0, l);
         b = $urandom_range(0, t);
      end else if (pick == 2) begin
         l = 0;
         t = 0;
         r = 4095;
         b = 4095;
      end else if (pick < 10) begin
         // Modest boxes give overlaps spread over the whole Q1.16 range.
         r = l + $urandom_range(1, 300);
         b = t + $urandom_range(1, 300);
         if (r > 4095) r = 4095;
         if (b > 4095) b = 4095;
      end
      return box_item(CMD_SET_REF, l, t, r, b, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
   endfunction

   function automatic req_item_type pick_candidate(input req_item_type anchor, input int pos,
                                                   input bit oversize, input logic lst);
      int d, pick, l, t, r, b;
      logic skp;
      pick = $urandom_range(0, 9);
      skp = ($urandom_range(0, 6) == 0);
      if (oversize) begin
         pick = 0;
         skp = 1'b0;
      end
      if (pick <= 5) begin
         case ($urandom_range(0, 4))
            0: d = 0;
            1: d = 1;
            2: d = 8;
            3: d = 64;
            default: d = 400;
         endcase
         // In an oversized set the exact copies sit past the table end, where
         // they must not win.
         if (oversize) d = (pos >= MAX_SET) ? 0 : $urandom_range(1, 8);
         l = jitter(anchor.left, d);
         t = jitter(anchor.top, d);
         r = jitter(anchor.right, d);
         b = jitter(anchor.bottom, d);
      end else if (pick == 6) begin
         l = $urandom_range(0, 4095);
         t = $urandom_range(0, 4095);
         r = $urandom_range(l, 4095);
         b = $urandom_range(t, 4095);
      end else if (pick == 7) begin
         l = $urandom_range(0, 4095);
         t = $urandom_range(0, 4095);
         r = $urandom_range(0, l);
         b = $urandom_range(0, t);
      end else if (pick == 8) begin
         l = $urandom_range(0, 4095);
         t = $urandom_range(0, 4095);
         r = $urandom_range(0, 4095);
         b = $urandom_range(0, 4095);
      end else begin
         l = $urandom_range(0, 1) * 4095;
         t = $urandom_range(0, 1) * 4095;
         r = $urandom_range(0, 1) * 4095;
         b = $urandom_range(0, 1) * 4095;
      end
      return box_item(CMD_CANDIDATE, l, t, r, b, skp, lst);
   endfunction

   // A set is normally a reference followed by candidates with the final one
   // marked last; now and then the last mark is dropped so the next reference
   // abandons the set, or the reference is left out so the old one is reused.
   task automatic random_set(input int n_cand, input bit with_ref);
      req_item_type it;
      bit drop_last;
      drop_last = ($urandom_range(0, 11) == 0) && (n_cand <= MAX_SET);
      if ($urandom_range(0, 3) == 0) sender_burst = !sender_burst;
      if (with_ref) begin
         gen_ref = pick_reference();
         push_box(gen_ref, 1'b0);
      end
      for (int i = 0; i < n_cand; i++) begin
         it = pick_candidate(gen_ref, i, n_cand > MAX_SET, (i == n_cand - 1) && !drop_last);
         push_box(it, 1'b0);
      end
   endtask

   // Back-to-back one-candidate sets while the receiver holds off, so the
   // result side backs up into the input; then the sender waits for all of it.
   task automatic pressure_run();
      push_control(ENT_DRAIN, 0);
      sender_burst = 1'b1;
      gen_ref = box_item(CMD_SET_REF, 500, 500, 700, 650, 1'b0, 1'b0);
      push_box(gen_ref, 1'b1);
      for (int i = 0; i < 40; i++) push_box(pick_candidate(gen_ref, 0, 1'b0, 1'b1), 1'b0);
      push_control(ENT_DRAIN, 0);
      sender_burst = 1'b0;
   endtask

   task automatic directed_items();
      // Candidates ahead of any reference see the all-zero reset box.
      push_box(box_item(CMD_CANDIDATE, 0, 0, 10, 10, 1'b0, 1'b1), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 5, 5, 5, 9, 1'b0, 1'b1), 1'b0);
      // A reference with skip and last set: both bits are ignored.
      push_box(box_item(CMD_SET_REF, 100, 100, 200, 200, 1'b1, 1'b1), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 100, 100, 200, 200, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 100, 100, 200, 200, 1'b1, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 300, 300, 400, 400, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 200, 200, 100, 100, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 150, 100, 250, 200, 1'b0, 1'b1), 1'b0);
      // Full frame reference against inverted, half and full frame candidates.
      push_box(box_item(CMD_SET_REF, 0, 0, 4095, 4095, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 4095, 0, 0, 4095, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 0, 0, 2048, 4095, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 0, 0, 4095, 4095, 1'b0, 1'b1), 1'b0);
      // Equal overlaps: the first one is kept until a strictly better one.
      push_box(box_item(CMD_SET_REF, 10, 10, 20, 20, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 10, 10, 15, 20, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 15, 10, 20, 20, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 10, 10, 18, 20, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 12, 12, 18, 18, 1'b0, 1'b1), 1'b0);
      // A reference in the middle of a set throws away the match so far.
      push_box(box_item(CMD_CANDIDATE, 10, 10, 20, 20, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_SET_REF, 10, 10, 20, 20, 1'b0, 1'b1), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 0, 0, 5, 5, 1'b0, 1'b1), 1'b0);
      // Both areas zero.
      push_box(box_item(CMD_SET_REF, 0, 0, 0, 0, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 0, 0, 0, 0, 1'b0, 1'b1), 1'b0);
      push_box(box_item(CMD_SET_REF, 1, 2, 4094, 4093, 1'b0, 1'b0), 1'b0);
      push_box(box_item(CMD_CANDIDATE, 1, 2, 4094, 4093, 1'b0, 1'b1), 1'b0);
   endtask

   initial begin : build_stream
      int unsigned thr_plan[8];
      int target;
      thr_plan[0] = 65536;
      thr_plan[1] = 0;
      thr_plan[2] = 32768;
      thr_plan[3] = $urandom_range(1, 65535);
      thr_plan[4] = 65535;
      thr_plan[5] = 8192;
      thr_plan[6] = $urandom_range(1, 65535);
      thr_plan[7] = 0;
      directed_items();
      for (int p = 0; p < 8; p++) begin
         push_control(ENT_THRESHOLD, thr_plan[p]);
         if (p == 1 || p == 5) random_set(MAX_SET + $urandom_range(1, 6), 1'b1);
         if (p == 2) pressure_run();
         target = gen_counted + PHASE_ITEMS;
         while (gen_counted < target)
            random_set(($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                   : $urandom_range(1, 6),
                       $urandom_range(0, 9) != 0);
      end
   end

   // ---------------------------------------------------------------- driver

   stream_entry_type cur_entry;
   bit have_entry = 1'b0;
   int gap_left = 0;
   int settle_left = 0;
   int hold_requests = 0;
   logic stream_done = 1'b0;

   always @(negedge clock) begin : driver
      logic push_nxt, csr_nxt;
      push_nxt = req_push;
      csr_nxt = csr_valid;
      if (req_taken) push_nxt = 1'b0;
      if (csr_taken) csr_nxt = 1'b0;
      if (!reset && !push_nxt && !csr_nxt) begin
         if (!have_entry && box_stream_q.size() != 0) begin
            cur_entry = box_stream_q.pop_front();
            have_entry = 1'b1;
            gap_left = cur_entry.gap;
            settle_left = SETTLE_CYCLES;
         end
         if (have_entry) begin
            case (cur_entry.kind)
               ENT_BOX: begin
                  if (gap_left != 0) begin
                     gap_left--;
                  end else begin
                     push_nxt = 1'b1;
                     req_item <= cur_entry.item;
                     if (cur_entry.hold_rx) hold_requests <= hold_requests + 1;
                     have_entry = 1'b0;
                  end
               end
               ENT_THRESHOLD: begin
                  // Registers change only with the block idle: all results
                  // in, then time for any trailing candidates to finish.
                  if (predicted_match_q.size() != 0) begin
                     settle_left = SETTLE_CYCLES;
                  end else if (settle_left != 0) begin
                     settle_left--;
                  end else begin
                     csr_nxt = 1'b1;
                     csr_data <= cur_entry.threshold;
                     have_entry = 1'b0;
                  end
               end
               default: begin
                  if (predicted_match_q.size() == 0) have_entry = 1'b0;
               end
            endcase
         end
      end
      req_push <= push_nxt;
      csr_valid <= csr_nxt;
      stream_done <= !reset && box_stream_q.size() == 0 && !have_entry && !push_nxt && !csr_nxt;
   end

   // ---------------------------------------------------------------- receiver

   int holds_served = 0;
   int hold_left = 0;
   logic rx_held;
   int rx_wait = 0;
   bit rx_burst = 1'b0;

   assign rx_held = (hold_left != 0);

   always @(negedge clock) begin : rx_hold
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end
   end

   always @(negedge clock) begin : receiver
      logic pop_nxt;
      pop_nxt = rsp_pop;
      if (rsp_taken) begin
         pop_nxt = 1'b0;
         rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      end
      if (!reset && !pop_nxt && !rx_held) begin
         if (rx_wait != 0) rx_wait--;
         else pop_nxt = 1'b1;
      end
      rsp_pop <= pop_nxt;
   end

   // ---------------------------------------------------------------- monitor

   task automatic log_mismatch(input string why, input rsp_item_type want,
                               input rsp_item_type got);
      n_mismatch++;
      if (n_mismatch <= 10)
         $display("%0t: %s: expected found=%0d index=%0d overlap=%0d, %s%0d %s%0d %s%0d",
                  $time, why, want.found, want.best_index, want.best_overlap,
                  "got found=", got.found, "index=", got.best_index,
                  "overlap=", got.best_overlap);
   endtask

   always @(posedge clock) begin : monitor
      rsp_item_type got, want;
      logic moved;
      req_taken <= req_push && !req_full;
      rsp_taken <= rsp_pop && !rsp_empty;
      csr_taken <= csr_valid && csr_ready;
      moved = 1'b0;
      if (!reset) begin
         // Results first: one accepted at this edge can only stem from an
         // earlier item.
         if (rsp_pop && !rsp_empty) begin
            moved = 1'b1;
            got = rsp_item;
            n_results++;
            if (got.found === 1'b1) n_found++;
            if (predicted_match_q.size() == 0) begin
               log_mismatch("result with none awaited", '0, got);
            end else begin
               want = predicted_match_q.pop_front();
               if (got.found !== want.found || got.best_index !== want.best_index
                   || got.best_overlap !== want.best_overlap)
                  log_mismatch("wrong result", want, got);
            end
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            thresh_q16 = csr_data;
            n_csr++;
         end
         if (req_push && !req_full) begin
            moved = 1'b1;
            n_items++;
            if (req_item.command == CMD_SET_REF) n_refs++;
            else if (req_item.skip) n_skipped++;
            if (score_item(req_item, want)) predicted_match_q = {predicted_match_q, want};
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- control

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("Timeout: no item moved for %0d cycles.", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : run_control
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!stream_done) @(posedge clock);
      while (predicted_match_q.size() != 0) @(negedge clock);
      // Anything the block still emits now has no expectation and is flagged.
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Run covered %0d items: %0d reference loads, %0d skipped candidates, %0d %s",
               n_items, n_refs, n_skipped, n_csr, "threshold writes.");
      $display("Checked %0d results, %0d of them with a match; %0d mismatches.",
               n_results, n_found, n_mismatch);
      if (n_mismatch == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
